[src/lpb_pkg.sv]
// ----------------------------------------------------------------------------
// lpb_pkg
// Shared types and constants for the page buffer pool: frame geometry,
// field widths and the layout of one frame table entry.
// ----------------------------------------------------------------------------
package lpb_pkg;

  localparam int POOL_FRAMES = 16;
  localparam int SLOT_W      = 4;
  localparam int PAGE_W      = 7;
  localparam int RANK_W      = 4;

  localparam logic [1:0] CMD_PAGE  = 2'd0;
  localparam logic [1:0] CMD_ROW   = 2'd1;
  localparam logic [1:0] CMD_DIRTY = 2'd2;

  localparam logic [12:0] PAGE_BYTES = 13'd4096;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              dirty;
    logic [RANK_W-1:0] rank;
  } frame_entry_t;

endpackage

[src/lpb_frame_ram.sv]
// ----------------------------------------------------------------------------
// lpb_frame_ram
// Frame table store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpb_frame_ram (
  input  logic                          clk,
  input  logic [lpb_pkg::SLOT_W-1:0]    rd_addr,
  output lpb_pkg::frame_entry_t         rd_data,
  input  logic                          wr_en,
  input  logic [lpb_pkg::SLOT_W-1:0]    wr_addr,
  input  lpb_pkg::frame_entry_t         wr_data
);
  import lpb_pkg::*;

  frame_entry_t mem_r [POOL_FRAMES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

[src/lru_page_buffer_pool.sv]
// ----------------------------------------------------------------------------
// lru_page_buffer_pool
// Fully associative pool of sixteen page frames kept in LRU order, with
// dirty tracking and write-back length reporting on eviction.
//
// Usage: raise start with a command on the in_ ports; the item is taken
// at a clock edge where start is high and busy is low. busy stays high
// until the result has been shown. One result comes per item, on the
// out_ ports for exactly one cycle with out_strobe high; the receiver
// cannot stall it and must take it then.
// Sequence: a command with an out-of-range page, or an unused code, goes
// straight to its result state after acceptance. Every other command walks the frame
// table memory once to search and, except a mark-dirty miss,
// walks it once more to update ranks and the chosen frame, and busy
// stays high until its result. The walks over the single-read-port frame
// memory set how long a command keeps the block busy.
// cfg_wr_en writes the file length register at any time the block is idle.
// Reset clears all frame valid bits, the frame count and the file length;
// the memory itself needs no clearing, invalid frames are never used.
// ----------------------------------------------------------------------------
module lru_page_buffer_pool (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_page_number,
  input  logic [15:0] in_row_number,
  input  logic [11:0] in_row_count,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_file_length_bytes,
  output logic        out_strobe,
  output logic        out_page_valid,
  output logic        out_hit,
  output logic [3:0]  out_frame_slot,
  output logic        out_fetch_from_file,
  output logic        out_evicted,
  output logic [6:0]  out_evict_page,
  output logic        out_write_back,
  output logic [12:0] out_write_bytes,
  output logic [11:0] out_row_offset
);
  import lpb_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPD    = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  localparam logic [4:0] WALK_END = 5'(POOL_FRAMES);

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [19:0] file_len_r;
  logic [POOL_FRAMES-1:0] valid_r, valid_nxt;
  logic [4:0]  in_use_r, in_use_nxt;

  // latched command
  logic [1:0]        cmd_r, cmd_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [11:0]       rows_r, rows_nxt;

  // scan results
  logic              hit_r, hit_nxt;
  logic [SLOT_W-1:0] hit_slot_r, hit_slot_nxt;
  logic [RANK_W-1:0] hit_rank_r, hit_rank_nxt;
  logic              free_r, free_nxt;
  logic [SLOT_W-1:0] free_slot_r, free_slot_nxt;
  logic              best_r, best_nxt;
  logic [SLOT_W-1:0] best_slot_r, best_slot_nxt;
  logic [RANK_W-1:0] best_rank_r, best_rank_nxt;
  logic [PAGE_W-1:0] best_page_r, best_page_nxt;
  logic              best_dirty_r, best_dirty_nxt;

  // update pass control
  logic [SLOT_W-1:0] sel_r, sel_nxt;
  logic [RANK_W-1:0] limit_r, limit_nxt;
  logic              miss_r, miss_nxt;

  // result registers
  logic        res_pv_r, res_pv_nxt;
  logic        res_hit_r, res_hit_nxt;
  logic [3:0]  res_slot_r, res_slot_nxt;
  logic        res_fetch_r, res_fetch_nxt;
  logic        res_ev_r, res_ev_nxt;
  logic [6:0]  res_evp_r, res_evp_nxt;
  logic        res_wb_r, res_wb_nxt;
  logic [12:0] res_wbytes_r, res_wbytes_nxt;
  logic [11:0] res_off_r, res_off_nxt;

  logic [SLOT_W-1:0] rd_addr;
  frame_entry_t      rd_data;
  logic              wr_en;
  frame_entry_t      wr_data;
  logic [SLOT_W-1:0] proc_idx;

  logic [15:0] eff_page;
  logic        eff_ok;
  logic [8:0]  file_pages;
  logic [11:0] last_len;
  logic [12:0] ev_len;

  lpb_frame_ram u_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (proc_idx),
    .wr_data (wr_data)
  );

  assign rd_addr  = cnt_r[SLOT_W-1:0];
  assign proc_idx = SLOT_W'(cnt_r - 5'd1);

  assign eff_page = (in_cmd == CMD_ROW) ? {4'd0, in_row_number[15:4]} : in_page_number;
  assign eff_ok   = (eff_page < 16'd128);

  assign file_pages = {1'b0, file_len_r[19:12]} + 9'(|file_len_r[11:0]);
  assign last_len   = {rows_r[3:0], 8'h00};
  assign ev_len     = ({1'b0, best_page_r} == rows_r[11:4]) ? {1'b0, last_len} : PAGE_BYTES;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    valid_nxt      = valid_r;
    in_use_nxt     = in_use_r;
    cmd_nxt        = cmd_r;
    page_nxt       = page_r;
    rows_nxt       = rows_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    hit_rank_nxt   = hit_rank_r;
    free_nxt       = free_r;
    free_slot_nxt  = free_slot_r;
    best_nxt       = best_r;
    best_slot_nxt  = best_slot_r;
    best_rank_nxt  = best_rank_r;
    best_page_nxt  = best_page_r;
    best_dirty_nxt = best_dirty_r;
    sel_nxt        = sel_r;
    limit_nxt      = limit_r;
    miss_nxt       = miss_r;
    res_pv_nxt     = res_pv_r;
    res_hit_nxt    = res_hit_r;
    res_slot_nxt   = res_slot_r;
    res_fetch_nxt  = res_fetch_r;
    res_ev_nxt     = res_ev_r;
    res_evp_nxt    = res_evp_r;
    res_wb_nxt     = res_wb_r;
    res_wbytes_nxt = res_wbytes_r;
    res_off_nxt    = res_off_r;
    wr_en          = 1'b0;
    wr_data        = rd_data;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt        = in_cmd;
          page_nxt       = eff_page[PAGE_W-1:0];
          rows_nxt       = in_row_count;
          cnt_nxt        = 5'd0;
          hit_nxt        = 1'b0;
          free_nxt       = 1'b0;
          best_nxt       = 1'b0;
          res_pv_nxt     = 1'b0;
          res_hit_nxt    = 1'b0;
          res_slot_nxt   = 4'd0;
          res_fetch_nxt  = 1'b0;
          res_ev_nxt     = 1'b0;
          res_evp_nxt    = 7'd0;
          res_wb_nxt     = 1'b0;
          res_wbytes_nxt = 13'd0;
          res_off_nxt    = (in_cmd == CMD_ROW) ? {in_row_number[3:0], 8'h00} : 12'd0;
          if (in_cmd == CMD_PAGE || in_cmd == CMD_ROW || in_cmd == CMD_DIRTY) begin
            res_pv_nxt = eff_ok;
            state_nxt  = eff_ok ? ST_SCAN : ST_EMIT;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_r != 5'd0) begin
          if (valid_r[proc_idx]) begin
            if (rd_data.page == page_r) begin
              hit_nxt      = 1'b1;
              hit_slot_nxt = proc_idx;
              hit_rank_nxt = rd_data.rank;
            end
            if (!best_r || rd_data.rank >= best_rank_r) begin
              best_nxt       = 1'b1;
              best_slot_nxt  = proc_idx;
              best_rank_nxt  = rd_data.rank;
              best_page_nxt  = rd_data.page;
              best_dirty_nxt = rd_data.dirty;
            end
          end else if (!free_r) begin
            free_nxt      = 1'b1;
            free_slot_nxt = proc_idx;
          end
        end
        if (cnt_r == WALK_END) begin
          state_nxt = ST_DECIDE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_DECIDE: begin
        cnt_nxt     = 5'd0;
        res_hit_nxt = hit_r;
        if (hit_r) begin
          res_slot_nxt = hit_slot_r;
          sel_nxt      = hit_slot_r;
          limit_nxt    = hit_rank_r;
          miss_nxt     = 1'b0;
          state_nxt    = ST_UPD;
        end else if (cmd_r == CMD_DIRTY) begin
          state_nxt = ST_EMIT;
        end else begin
          miss_nxt      = 1'b1;
          res_fetch_nxt = ({2'b00, page_r} < file_pages);
          if (free_r) begin
            sel_nxt    = free_slot_r;
            in_use_nxt = in_use_r + 5'd1;
          end else begin
            sel_nxt        = best_slot_r;
            res_ev_nxt     = 1'b1;
            res_evp_nxt    = best_page_r;
            res_wb_nxt     = best_dirty_r && (ev_len != 13'd0);
            res_wbytes_nxt = (best_dirty_r && (ev_len != 13'd0)) ? ev_len : 13'd0;
          end
          res_slot_nxt = free_r ? free_slot_r : best_slot_r;
          valid_nxt[free_r ? free_slot_r : best_slot_r] = 1'b1;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (cnt_r != 5'd0) begin
          wr_en = 1'b1;
          if (proc_idx == sel_r) begin
            if (cmd_r == CMD_DIRTY) begin
              wr_data.dirty = 1'b1;
            end else begin
              wr_data.rank = '0;
              if (miss_r) begin
                wr_data.page  = page_r;
                wr_data.dirty = 1'b0;
              end
            end
          end else if (cmd_r != CMD_DIRTY && valid_r[proc_idx]
                       && (miss_r || rd_data.rank < limit_r)) begin
            wr_data.rank = rd_data.rank + RANK_W'(1);
          end
        end
        if (cnt_r == WALK_END) begin
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_EMIT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= 5'd0;
      valid_r    <= '0;
      in_use_r   <= 5'd0;
      file_len_r <= 20'd0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      valid_r  <= valid_nxt;
      in_use_r <= in_use_nxt;
      if (cfg_wr_en) begin
        file_len_r <= cfg_file_length_bytes;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    page_r       <= page_nxt;
    rows_r       <= rows_nxt;
    hit_r        <= hit_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_rank_r   <= hit_rank_nxt;
    free_r       <= free_nxt;
    free_slot_r  <= free_slot_nxt;
    best_r       <= best_nxt;
    best_slot_r  <= best_slot_nxt;
    best_rank_r  <= best_rank_nxt;
    best_page_r  <= best_page_nxt;
    best_dirty_r <= best_dirty_nxt;
    sel_r        <= sel_nxt;
    limit_r      <= limit_nxt;
    miss_r       <= miss_nxt;
    res_pv_r     <= res_pv_nxt;
    res_hit_r    <= res_hit_nxt;
    res_slot_r   <= res_slot_nxt;
    res_fetch_r  <= res_fetch_nxt;
    res_ev_r     <= res_ev_nxt;
    res_evp_r    <= res_evp_nxt;
    res_wb_r     <= res_wb_nxt;
    res_wbytes_r <= res_wbytes_nxt;
    res_off_r    <= res_off_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_strobe          = (state_r == ST_EMIT);
  assign out_page_valid      = res_pv_r;
  assign out_hit             = res_hit_r;
  assign out_frame_slot      = res_slot_r;
  assign out_fetch_from_file = res_fetch_r;
  assign out_evicted         = res_ev_r;
  assign out_evict_page      = res_evp_r;
  assign out_write_back      = res_wb_r;
  assign out_write_bytes     = res_wbytes_r;
  assign out_row_offset      = res_off_r;

endmodule

[tb/lru_page_buffer_pool_checker.sv]
// ----------------------------------------------------------------------------
// lru_page_buffer_pool_checker
// Watches the command and result channels of the page buffer pool, keeps
// its own copy of the frame table and file length, predicts each result
// and compares it field by field with what the block shows.
// ----------------------------------------------------------------------------
module lru_page_buffer_pool_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_page_number,
  input  logic [15:0] in_row_number,
  input  logic [11:0] in_row_count,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_file_length_bytes,
  input  logic        out_strobe,
  input  logic        out_page_valid,
  input  logic        out_hit,
  input  logic [3:0]  out_frame_slot,
  input  logic        out_fetch_from_file,
  input  logic        out_evicted,
  input  logic [6:0]  out_evict_page,
  input  logic        out_write_back,
  input  logic [12:0] out_write_bytes,
  input  logic [11:0] out_row_offset,
  output int          fail_count,
  output int          pending_count
);
  import lpb_pkg::*;

  localparam int PAGE_LIMIT   = 128;
  localparam int ROWS_IN_PAGE = 16;
  localparam int ROW_BYTES    = 256;

  typedef struct packed {
    logic        page_valid;
    logic        hit;
    logic [3:0]  frame_slot;
    logic        fetch_from_file;
    logic        evicted;
    logic [6:0]  evict_page;
    logic        write_back;
    logic [12:0] write_bytes;
    logic [11:0] row_offset;
  } pool_result_t;

  pool_result_t result_q[$];

  logic [19:0] file_len;
  int          frame_pg  [POOL_FRAMES];
  bit          frame_vld [POOL_FRAMES];
  bit          frame_drt [POOL_FRAMES];
  int          frame_age [POOL_FRAMES];
  int          used_frames;

  assign pending_count = result_q.size();

  function automatic int lookup_frame(int pg);
    for (int i = 0; i < POOL_FRAMES; i++)
      if (frame_vld[i] && frame_pg[i] == pg) return i;
    return -1;
  endfunction

  function automatic void make_recent(int s, longint lim);
    for (int i = 0; i < POOL_FRAMES; i++)
      if (i != s && frame_vld[i] && frame_age[i] < lim) frame_age[i]++;
    frame_age[s] = 0;
  endfunction

  function automatic void touch_page(int pg, int rows, ref pool_result_t r);
    int s;
    int best;
    int len;
    int fpages;
    if (pg >= PAGE_LIMIT) return;
    r.page_valid = 1'b1;
    s = lookup_frame(pg);
    if (s >= 0) begin
      r.hit = 1'b1;
      r.frame_slot = s[3:0];
      make_recent(s, frame_age[s]);
      return;
    end
    if (used_frames < POOL_FRAMES)
      for (int i = 0; i < POOL_FRAMES && s < 0; i++)
        if (!frame_vld[i]) s = i;
    if (s < 0) begin
      best = 0;
      for (int i = 0; i < POOL_FRAMES; i++)
        if (frame_vld[i] && (s < 0 || frame_age[i] >= best)) begin
          s = i;
          best = frame_age[i];
        end
      if (s < 0) s = 0;
      r.evicted = 1'b1;
      r.evict_page = frame_pg[s][6:0];
      len = PAGE_BYTES;
      if (frame_pg[s] == rows / ROWS_IN_PAGE) len = (rows % ROWS_IN_PAGE) * ROW_BYTES;
      if (frame_drt[s] && len > 0) begin
        r.write_back = 1'b1;
        r.write_bytes = len[12:0];
      end
      frame_vld[s] = 0;
    end else begin
      used_frames++;
    end
    fpages = (file_len + PAGE_BYTES - 1) / PAGE_BYTES;
    r.fetch_from_file = pg < fpages;
    frame_pg[s] = pg;
    frame_vld[s] = 1;
    frame_drt[s] = 0;
    make_recent(s, 64'hFFFF_FFFF);
    r.frame_slot = s[3:0];
  endfunction

  function automatic pool_result_t predict_pool(logic [1:0] cmd, int pg, int row, int rows);
    pool_result_t r;
    int s;
    r = '0;
    case (cmd)
      CMD_PAGE: touch_page(pg, rows, r);
      CMD_ROW: begin
        r.row_offset = 12'((row % ROWS_IN_PAGE) * ROW_BYTES);
        touch_page(row / ROWS_IN_PAGE, rows, r);
      end
      CMD_DIRTY: begin
        r.page_valid = pg < PAGE_LIMIT;
        s = lookup_frame(pg);
        if (s >= 0) begin
          frame_drt[s] = 1;
          r.hit = 1'b1;
          r.frame_slot = s[3:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pool_result_t exp_r;
    pool_result_t act_r;
    if (!rst_n) begin
      file_len <= '0;
      used_frames = 0;
      for (int i = 0; i < POOL_FRAMES; i++) begin
        frame_pg[i] = 0; frame_vld[i] = 0; frame_drt[i] = 0; frame_age[i] = 0;
      end
      fail_count <= 0;
      result_q.delete();
    end else begin
      if (cfg_wr_en) file_len <= cfg_file_length_bytes;
      if (out_strobe) begin
        act_r = '{out_page_valid, out_hit, out_frame_slot, out_fetch_from_file,
                  out_evicted, out_evict_page, out_write_back, out_write_bytes,
                  out_row_offset};
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, act_r);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (act_r != exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, act_r);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        result_q.push_back(predict_pool(in_cmd, in_page_number, in_row_number,
                                        in_row_count));
    end
  end

endmodule

[tb/tb_lru_page_buffer_pool.sv]
// ----------------------------------------------------------------------------
// tb_lru_page_buffer_pool
// Drives directed and random page, row, mark-dirty and unused-code commands through the
// page buffer pool across several file lengths, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_lru_page_buffer_pool;
  import lpb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [15:0] in_page_number;
  logic [15:0] in_row_number;
  logic [11:0] in_row_count;
  logic        cfg_wr_en;
  logic [19:0] cfg_file_length_bytes;
  logic        out_strobe, out_page_valid, out_hit, out_fetch_from_file;
  logic        out_evicted, out_write_back;
  logic [3:0]  out_frame_slot;
  logic [6:0]  out_evict_page;
  logic [12:0] out_write_bytes;
  logic [11:0] out_row_offset;
  int          fail_count;
  int          pending_count;
  int          cycle_count;

  lru_page_buffer_pool u_dut (.*);
  lru_page_buffer_pool_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [15:0] pg, logic [15:0] row,
                           logic [11:0] rows);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    in_cmd <= cmd;
    in_page_number <= pg;
    in_row_number <= row;
    in_row_count <= rows;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    // the block is busy on the next edge anyway
    @(posedge clk);
  endtask

  task automatic write_file_length(logic [19:0] len);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_file_length_bytes <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly small pages so hits, evictions and dirty frames are common
  task automatic random_item();
    logic [15:0] pg;
    logic [15:0] row;
    logic [1:0]  cmd;
    int sel;
    sel = $urandom_range(0, 19);
    pg  = (sel == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
    row = (sel == 1) ? 16'($urandom) : 16'($urandom_range(0, 24 * 16 - 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: cmd = CMD_PAGE;
      4, 5, 6:    cmd = CMD_ROW;
      7, 8:       cmd = CMD_DIRTY;
      default:    cmd = 2'($urandom);
    endcase
    send_item(cmd, pg, row, ($urandom_range(0, 3) == 0) ? 12'($urandom) :
              12'($urandom_range(0, 24 * 16)));
  endtask

  initial begin
    logic [19:0] lens [6];
    lens = '{20'd0, 20'hFFFFF, 20'd524288, 20'd1, 20'd20480, 20'd40961};
    rst_n = 0;
    start = 0;
    in_cmd = CMD_PAGE;
    in_page_number = 0;
    in_row_number = 0;
    in_row_count = 0;
    cfg_wr_en = 0;
    cfg_file_length_bytes = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_file_length(20'd8192);
    // directed: range edges, each command, unused code, full pool eviction
    send_item(CMD_PAGE, 16'd0, 16'd0, 12'd0);
    send_item(CMD_PAGE, 16'd127, 16'd0, 12'd0);
    send_item(CMD_PAGE, 16'd128, 16'd0, 12'd0);
    send_item(CMD_PAGE, 16'hFFFF, 16'd0, 12'd0);
    send_item(CMD_ROW, 16'd0, 16'hFFFF, 12'hFFF);
    send_item(CMD_ROW, 16'd0, 16'd2047, 12'd0);
    send_item(CMD_DIRTY, 16'd0, 16'd0, 12'd0);
    send_item(CMD_DIRTY, 16'd50, 16'd0, 12'd0);
    send_item(CMD_DIRTY, 16'hFFFF, 16'd0, 12'd0);
    send_item(2'd3, 16'hFFFF, 16'hFFFF, 12'hFFF);
    for (int i = 1; i <= 15; i++) send_item(CMD_PAGE, 16'(i), 16'd0, 12'd0);
    send_item(CMD_PAGE, 16'd0, 16'd0, 12'd0);
    send_item(CMD_DIRTY, 16'd1, 16'd0, 12'd0);
    send_item(CMD_PAGE, 16'd100, 16'd0, 12'd2048);
    for (int p = 0; p < 6; p++) begin
      write_file_length(lens[p]);
      repeat (90) random_item();
    end
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
